// ----- hdl/eart_pkg.sv -----
// Shared types, constants and helpers of the encoder angle/rate tracker.
// No dependencies; every other file imports this package.
package eart_pkg;

	localparam int COUNTS_PER_TURN_DEF = 4096;
	localparam int ANGLE_W  = 12;
	localparam int STAT_W   = 8;
	localparam int TIME_W   = 32;
	localparam int RATE_W   = 32;
	localparam int WIN_W    = 16;
	localparam int NUM_W    = 53;              // |speed diff| * 1e6 fits here
	localparam int CNT_W    = $clog2(NUM_W);
	localparam int MICRO    = 1000000;

	localparam int STAT_DETECTED = 5;
	localparam int STAT_WEAK     = 4;
	localparam int STAT_STRONG   = 3;

	localparam logic ACT_SYNC = 1'b1;

	localparam int PADDR_W = 4;
	localparam logic [1:0] REG_MIN_WINDOW = 2'd0;
	localparam logic [1:0] REG_MAX_STEP   = 2'd1;
	localparam logic [1:0] REG_CENTRE     = 2'd2;

	localparam logic [WIN_W-1:0]   MIN_WINDOW_RST = 16'd1000;
	localparam logic [ANGLE_W-1:0] MAX_STEP_RST   = 12'd400;
	localparam logic [ANGLE_W-1:0] CENTRE_RST     = 12'd0;

	typedef struct packed {
		logic [WIN_W-1:0]   min_window;
		logic [ANGLE_W-1:0] max_step;
		logic [ANGLE_W-1:0] centre;
	} cfg_t;

	typedef struct packed {
		logic latch;
		logic eval;
		logic div_step;
		logic sat_speed;
		logic load_accel;
		logic sat_accel;
		logic push;
	} cmd_t;

	typedef struct packed {
		logic rates_go;
		logic div_last;
		logic slot_free;
	} sts_t;

	typedef struct packed {
		logic [ANGLE_W-1:0]       angle_counts;
		logic signed [RATE_W-1:0] total_counts;
		logic signed [RATE_W-1:0] speed_cps;
		logic signed [RATE_W-1:0] accel_cps2;
		logic                     sample_rejected;
		logic                     rates_updated;
		logic                     glitch_seen;
	} res_t;

	// Apply sign to an unsigned quotient and clamp to 32-bit signed.
	function automatic logic [RATE_W-1:0] sat_mag(input logic neg,
			input logic [NUM_W-1:0] q);
		logic [RATE_W-1:0] r;
		if (!neg) begin
			if (q > NUM_W'(32'h7FFF_FFFF)) r = 32'h7FFF_FFFF;
			else r = q[RATE_W-1:0];
		end else begin
			if (q > NUM_W'(33'h0_8000_0000)) r = 32'h8000_0000;
			else r = RATE_W'(-q[RATE_W-1:0]);
		end
		return r;
	endfunction

endpackage

// ----- hdl/eart_if.sv -----
// Valid/ready channel interfaces for sample words and result words.
// Depends on eart_pkg.
interface eart_in_if;
	import eart_pkg::*;
	logic               valid;
	logic               ready;
	logic               action;
	logic [ANGLE_W-1:0] raw_angle;
	logic [STAT_W-1:0]  status_byte;
	logic [TIME_W-1:0]  time_us;
	modport source (output valid, action, raw_angle, status_byte, time_us, input ready);
	modport sink (input valid, action, raw_angle, status_byte, time_us, output ready);
endinterface

interface eart_out_if;
	import eart_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [ANGLE_W-1:0]       angle_counts;
	logic signed [RATE_W-1:0] total_counts;
	logic signed [RATE_W-1:0] speed_cps;
	logic signed [RATE_W-1:0] accel_cps2;
	logic                     sample_rejected;
	logic                     rates_updated;
	logic                     glitch_seen;
	modport source (output valid, angle_counts, total_counts, speed_cps, accel_cps2,
		sample_rejected, rates_updated, glitch_seen, input ready);
	modport sink (input valid, angle_counts, total_counts, speed_cps, accel_cps2,
		sample_rejected, rates_updated, glitch_seen, output ready);
endinterface

// ----- hdl/eart_ctrl.sv -----
// Sequencer of the tracker: steps the datapath through evaluate, two divisions
// (only when the rates are recomputed) and result hand-off. Depends on eart_pkg.
module eart_ctrl import eart_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EVAL  = 3'd1;
	localparam logic [2:0] ST_DIV_S = 3'd2;
	localparam logic [2:0] ST_SAT_S = 3'd3;
	localparam logic [2:0] ST_MUL_A = 3'd4;
	localparam logic [2:0] ST_DIV_A = 3'd5;
	localparam logic [2:0] ST_SAT_A = 3'd6;
	localparam logic [2:0] ST_PUSH  = 3'd7;

	logic [2:0] state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.latch = in_valid;
				if (in_valid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d = sts.rates_go ? ST_DIV_S : ST_PUSH;
			end
			ST_DIV_S: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = ST_SAT_S;
			end
			ST_SAT_S: begin
				cmd.sat_speed = 1'b1;
				state_d = ST_MUL_A;
			end
			ST_MUL_A: begin
				cmd.load_accel = 1'b1;
				state_d = ST_DIV_A;
			end
			ST_DIV_A: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = ST_SAT_A;
			end
			ST_SAT_A: begin
				cmd.sat_accel = 1'b1;
				state_d = ST_PUSH;
			end
			ST_PUSH: begin
				cmd.push = sts.slot_free;
				if (sts.slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

endmodule

// ----- hdl/eart_dp.sv -----
// Datapath of the tracker: tracking state, unwrap, saturating total, shared
// restoring divider and result register. Depends on eart_pkg.
module eart_dp import eart_pkg::*; #(
	parameter int COUNTS_PER_TURN = COUNTS_PER_TURN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic               action,
	input  logic [ANGLE_W-1:0] raw_angle,
	input  logic [STAT_W-1:0]  status_byte,
	input  logic [TIME_W-1:0]  time_us,
	output logic               out_valid,
	input  logic               out_ready,
	output res_t               res
);

	localparam int CPT_W  = $clog2(COUNTS_PER_TURN);
	localparam int STEP_W = (CPT_W + 2 > ANGLE_W + 2) ? CPT_W + 2 : ANGLE_W + 2;
	localparam logic signed [STEP_W-1:0] HALF  = STEP_W'(COUNTS_PER_TURN / 2);
	localparam logic signed [STEP_W-1:0] CPT_S = STEP_W'(COUNTS_PER_TURN);

	logic               act_q;
	logic [ANGLE_W-1:0] raw_q;
	logic [STAT_W-1:0]  stat_q;
	logic [TIME_W-1:0]  now_q;

	logic [ANGLE_W-1:0]       prev_angle_q, cur_angle_q;
	logic [TIME_W-1:0]        prev_time_q;
	logic signed [RATE_W-1:0] total_q, cur_speed_q, prev_speed_q, cur_accel_q;
	logic                     rej_q, upd_q, gli_q;

	logic [TIME_W-1:0] dt_q;
	logic [NUM_W-1:0]  num_q;
	logic [TIME_W:0]   rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              neg_q;

	logic                     out_valid_q;
	res_t                     out_q;

	logic                     magnet_ok, is_sync, win, glitch;
	logic [TIME_W-1:0]        dt;
	logic signed [STEP_W-1:0] d0, d1, step;
	logic [STEP_W-1:0]        mag;
	logic signed [RATE_W:0]   tsum, adiff;
	logic [RATE_W:0]          amag;
	logic [RATE_W-1:0]        tsat, seed;
	logic [TIME_W:0]          rem_sh;
	logic                     fits;

	assign magnet_ok = stat_q[STAT_DETECTED] & ~stat_q[STAT_WEAK] & ~stat_q[STAT_STRONG];
	assign is_sync   = (act_q == ACT_SYNC);
	assign dt        = now_q - prev_time_q;
	assign win       = (dt != '0) && (dt >= TIME_W'(cfg.min_window));

	// Unwrap the raw step into one turn.
	assign d0   = $signed(STEP_W'(raw_q)) - $signed(STEP_W'(prev_angle_q));
	assign d1   = (d0 > HALF) ? d0 - CPT_S : d0;
	assign step = (d1 < -HALF) ? d1 + CPT_S : d1;
	assign mag  = step[STEP_W-1] ? STEP_W'(-step) : STEP_W'(step);
	assign glitch = mag > STEP_W'(cfg.max_step);

	assign tsum = $signed({total_q[RATE_W-1], total_q}) + $signed((RATE_W+1)'(step));
	assign tsat = (tsum[RATE_W] != tsum[RATE_W-1])
		? (tsum[RATE_W] ? 32'h8000_0000 : 32'h7FFF_FFFF) : tsum[RATE_W-1:0];
	assign seed = RATE_W'(raw_q) - RATE_W'(cfg.centre);

	assign adiff = $signed({cur_speed_q[RATE_W-1], cur_speed_q})
		- $signed({prev_speed_q[RATE_W-1], prev_speed_q});
	assign amag  = adiff[RATE_W] ? (RATE_W+1)'(-adiff) : (RATE_W+1)'(adiff);

	// One restoring division step per cycle.
	assign rem_sh = {rem_q[TIME_W-1:0], num_q[NUM_W-1]};
	assign fits   = rem_sh >= {1'b0, dt_q};

	assign sts.rates_go  = magnet_ok && !is_sync && win && !glitch;
	assign sts.div_last  = (cnt_q == CNT_W'(NUM_W - 1));
	assign sts.slot_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign res       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_angle_q <= '0;
			prev_time_q  <= '0;
			cur_angle_q  <= '0;
			total_q      <= '0;
			cur_speed_q  <= '0;
			prev_speed_q <= '0;
			cur_accel_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.eval && magnet_ok) begin
				if (is_sync) begin
					prev_angle_q <= raw_q;
					prev_time_q  <= now_q;
					total_q      <= seed;
				end else begin
					cur_angle_q <= raw_q;
					if (win) begin
						prev_angle_q <= raw_q;
						prev_time_q  <= now_q;
						if (glitch) begin
							cur_speed_q  <= '0;
							prev_speed_q <= '0;
							cur_accel_q  <= '0;
						end else begin
							total_q <= tsat;
						end
					end
				end
			end
			if (cmd.sat_speed) cur_speed_q <= sat_mag(neg_q, num_q);
			if (cmd.load_accel) prev_speed_q <= cur_speed_q;
			if (cmd.sat_accel) cur_accel_q <= sat_mag(neg_q, num_q);
			if (cmd.push) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			act_q  <= action;
			raw_q  <= raw_angle;
			stat_q <= status_byte;
			now_q  <= time_us;
		end
		if (cmd.eval) begin
			rej_q <= !magnet_ok;
			upd_q <= magnet_ok && !is_sync && win;
			gli_q <= magnet_ok && !is_sync && win && glitch;
			dt_q  <= dt;
			num_q <= NUM_W'(mag) * NUM_W'(MICRO);
			neg_q <= step[STEP_W-1];
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.load_accel) begin
			num_q <= NUM_W'(amag) * NUM_W'(MICRO);
			neg_q <= adiff[RATE_W];
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= fits ? rem_sh - {1'b0, dt_q} : rem_sh;
			num_q <= {num_q[NUM_W-2:0], fits};
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.push) begin
			out_q.angle_counts    <= cur_angle_q;
			out_q.total_counts    <= total_q;
			out_q.speed_cps       <= cur_speed_q;
			out_q.accel_cps2      <= cur_accel_q;
			out_q.sample_rejected <= rej_q;
			out_q.rates_updated   <= upd_q;
			out_q.glitch_seen     <= gli_q;
		end
	end

`ifndef SYNTHESIS
	a_rej_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.sample_rejected |-> !out_q.rates_updated && !out_q.glitch_seen)
		else $error("rejected word reports an update");
	a_glitch_upd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.glitch_seen |-> out_q.rates_updated)
		else $error("glitch without update");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |=> rem_q < {1'b0, dt_q})
		else $error("divider remainder out of range");
	a_glitch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eval && sts.rates_go |-> win && !glitch && dt != '0)
		else $error("divider started on zero or glitch step");
`endif

endmodule

// ----- hdl/encoder_angle_rate_tracker.sv -----
// Encoder angle/rate tracker, top level: APB register file, sequencer and
// datapath. Depends on eart_pkg, eart_if, eart_ctrl and eart_dp.
//
// Takes one sample word (sync flag, 12-bit absolute angle, sensor status,
// microsecond timestamp) at a time on "sample" and returns exactly one result
// word on "result": current angle, saturating cumulative angle, velocity in
// counts/s and acceleration in counts/s^2, plus rejected/updated/glitch
// flags. A word whose magnet status is bad, a sync word, or a sample before
// the minimum window has elapsed goes from evaluation straight to the result
// hand-off. For a sample that recomputes the rates, the velocity and then the
// acceleration go through one shared restoring divider that retires one
// quotient bit per cycle over a 53-bit numerator; the speed is saturated and
// the acceleration numerator formed between them. A glitch step (larger
// than max_step_counts) zeroes the rates and skips the divider.
// The result register frees the datapath: the next sample is taken while a
// result still waits for ready. Registers (APB, 32-bit data): 0x0
// min_window_us, 0x4 max_step_counts, 0x8 centre_counts; write them only
// while no sample is in flight.
module encoder_angle_rate_tracker import eart_pkg::*; #(
	parameter int COUNTS_PER_TURN = COUNTS_PER_TURN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	eart_in_if.sink            sample,
	eart_out_if.source         result
);

	cfg_t       cfg_q;
	cmd_t       cmd;
	sts_t       sts;
	res_t       res;
	logic [1:0] reg_idx;
	logic       wr_en;

	// Register file: zero wait states, decode on the word index.
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_window <= MIN_WINDOW_RST;
			cfg_q.max_step   <= MAX_STEP_RST;
			cfg_q.centre     <= CENTRE_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MIN_WINDOW: cfg_q.min_window <= pwdata[WIN_W-1:0];
				REG_MAX_STEP:   cfg_q.max_step   <= pwdata[ANGLE_W-1:0];
				REG_CENTRE:     cfg_q.centre     <= pwdata[ANGLE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MIN_WINDOW: prdata = 32'(cfg_q.min_window);
			REG_MAX_STEP:   prdata = 32'(cfg_q.max_step);
			REG_CENTRE:     prdata = 32'(cfg_q.centre);
			default:        prdata = '0;
		endcase
	end

	eart_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	eart_dp #(.COUNTS_PER_TURN(COUNTS_PER_TURN)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cmd         (cmd),
		.sts         (sts),
		.action      (sample.action),
		.raw_angle   (sample.raw_angle),
		.status_byte (sample.status_byte),
		.time_us     (sample.time_us),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.res         (res)
	);

	// Drive the result word from the datapath's output register.
	assign result.angle_counts    = res.angle_counts;
	assign result.total_counts    = res.total_counts;
	assign result.speed_cps       = res.speed_cps;
	assign result.accel_cps2      = res.accel_cps2;
	assign result.sample_rejected = res.sample_rejected;
	assign result.rates_updated   = res.rates_updated;
	assign result.glitch_seen     = res.glitch_seen;

endmodule
